// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/itaf_pkg.sv
// Types and constants of the integer to ASCII formatter.
package itaf_pkg;

    localparam int VALUE_W     = 64;
    localparam int PREC_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int BCD_DIGITS  = 20;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int CONV_STEPS  = VALUE_W;

    // slave tdata / tuser bit positions
    localparam int TD_UPPER   = 64;
    localparam int TD_PREC_LO = 65;
    localparam int TD_SPACE   = 71;
    localparam int TD_PLUS    = 72;
    localparam int TU_HEX     = 0;
    localparam int TU_NEG     = 1;
    localparam int TU_SIGN    = 2;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;

    // classified command handed from front to back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               hex_base;
        logic               upper_case;
        logic [PREC_W-1:0]  precision;   // already clamped
        logic [CHAR_W-1:0]  sign_char;   // CH_NONE = no sign
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT
    } t_back_state;

endpackage

// File: rtl/core/itaf_queue.sv
// Short command queue between the front and back parts.
module itaf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itaf_pkg::t_cmd i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output itaf_pkg::t_cmd o_pop_data,
    output logic           o_empty
);

    localparam int DEPTH = itaf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itaf_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/core/itaf_front.sv
// Front part: accepts input words, picks the sign and clamps precision.
module itaf_front #(
    parameter int MAX_PRECISION = 32
) (
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [itaf_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [itaf_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    input  logic                               i_queue_full,
    output logic                               o_push,
    output itaf_pkg::t_cmd                     o_push_data
);

    localparam logic [itaf_pkg::PREC_W-1:0] MAX_PREC_C = itaf_pkg::PREC_W'(MAX_PRECISION);

    logic [itaf_pkg::PREC_W-1:0] w_prec_raw;
    logic                        w_neg;
    logic                        w_sign_en;
    logic                        w_space;
    logic                        w_plus;

    assign w_prec_raw = i_s_axis_tdata[itaf_pkg::TD_PREC_LO +: itaf_pkg::PREC_W];
    assign w_neg      = i_s_axis_tuser[itaf_pkg::TU_NEG];
    assign w_sign_en  = i_s_axis_tuser[itaf_pkg::TU_SIGN];
    assign w_space    = i_s_axis_tdata[itaf_pkg::TD_SPACE];
    assign w_plus     = i_s_axis_tdata[itaf_pkg::TD_PLUS];

    assign o_s_axis_tready = !i_queue_full;
    assign o_push          = i_s_axis_tvalid && !i_queue_full;

    always_comb begin
        o_push_data.value      = i_s_axis_tdata[itaf_pkg::VALUE_W-1:0];
        o_push_data.hex_base   = i_s_axis_tuser[itaf_pkg::TU_HEX];
        o_push_data.upper_case = i_s_axis_tdata[itaf_pkg::TD_UPPER];
        o_push_data.precision  = (w_prec_raw > MAX_PREC_C) ? MAX_PREC_C : w_prec_raw;
        // sign priority: minus, then space, then plus
        if (!w_sign_en) begin
            o_push_data.sign_char = itaf_pkg::CH_NONE;
        end else if (w_neg) begin
            o_push_data.sign_char = itaf_pkg::CH_MINUS;
        end else if (w_space) begin
            o_push_data.sign_char = itaf_pkg::CH_SPACE;
        end else if (w_plus) begin
            o_push_data.sign_char = itaf_pkg::CH_PLUS;
        end else begin
            o_push_data.sign_char = itaf_pkg::CH_NONE;
        end
    end

endmodule

// File: rtl/core/itaf_back.sv
// Back part: digit conversion, leading digit scan and character emission.
module itaf_back #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  itaf_pkg::t_cmd                  i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [itaf_pkg::CHAR_W-1:0]     o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int STEP_W = $clog2(itaf_pkg::CONV_STEPS);
    localparam int BCD_W  = itaf_pkg::BCD_W;
    localparam int PREC_W = itaf_pkg::PREC_W;
    localparam int CHAR_W = itaf_pkg::CHAR_W;
    localparam int VAL_W  = itaf_pkg::VALUE_W;
    // digits above the kept range; empty when all digits are kept
    localparam logic [BCD_W-1:0] HIGH_MASK = {BCD_W{1'b1}} << (4 * MAX_DIGITS);

    // add 3 to every BCD digit of 5 or more before the next shift
    function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int k = 0; k < itaf_pkg::BCD_DIGITS; k++) begin
            if (bcd[4*k +: 4] >= 4'd5) begin
                res[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = itaf_pkg::CH_ZERO + {4'b0000, d};
        end else if (upper) begin
            c = itaf_pkg::CH_UPPER_A + {4'b0000, d - 4'd10};
        end else begin
            c = itaf_pkg::CH_LOWER_A + {4'b0000, d - 4'd10};
        end
        return c;
    endfunction

    itaf_pkg::t_back_state r_state, n_state;
    logic [VAL_W-1:0]      r_bin, n_bin;
    logic [BCD_W-1:0]      r_digits, n_digits;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [PREC_W-1:0]     r_pad, n_pad;
    logic [PREC_W-1:0]     r_prec, n_prec;
    logic [CHAR_W-1:0]     r_sign, n_sign;
    logic                  r_upper, n_upper;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic                  w_slot;
    logic [3:0]            w_nib;
    logic                  w_found;
    logic [PREC_W-1:0]     w_count;
    logic [PREC_W-1:0]     w_scan_pad;
    logic [BCD_W-1:0]      w_adj;

    assign w_slot     = !r_out_valid || i_m_axis_tready;
    assign w_nib      = r_digits[{r_idx, 2'b00} +: 4];
    assign w_found    = (|(r_digits & HIGH_MASK)) || (w_nib != 4'd0) || (r_idx == '0);
    assign w_count    = PREC_W'(r_idx) + PREC_W'(1);
    assign w_scan_pad = (r_prec > w_count) ? (r_prec - w_count) : '0;
    assign w_adj      = dabble_adjust(r_digits);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itaf_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.hex_base ? itaf_pkg::ST_SCAN : itaf_pkg::ST_CONV;
                end
            end
            itaf_pkg::ST_CONV: begin
                if (r_step == STEP_W'(itaf_pkg::CONV_STEPS - 1)) begin
                    n_state = itaf_pkg::ST_SCAN;
                end
            end
            itaf_pkg::ST_SCAN: begin
                if (w_found) begin
                    if (r_sign != itaf_pkg::CH_NONE) begin
                        n_state = itaf_pkg::ST_SIGN;
                    end else if (w_scan_pad != '0) begin
                        n_state = itaf_pkg::ST_PAD;
                    end else begin
                        n_state = itaf_pkg::ST_DIGIT;
                    end
                end
            end
            itaf_pkg::ST_SIGN: begin
                if (w_slot) begin
                    n_state = (r_pad != '0) ? itaf_pkg::ST_PAD : itaf_pkg::ST_DIGIT;
                end
            end
            itaf_pkg::ST_PAD: begin
                if (w_slot && r_pad == PREC_W'(1)) begin
                    n_state = itaf_pkg::ST_DIGIT;
                end
            end
            itaf_pkg::ST_DIGIT: begin
                if (w_slot && r_idx == '0) begin
                    n_state = itaf_pkg::ST_IDLE;
                end
            end
            default: n_state = itaf_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_bin       = r_bin;
        n_digits    = r_digits;
        n_step      = r_step;
        n_idx       = r_idx;
        n_pad       = r_pad;
        n_prec      = r_prec;
        n_sign      = r_sign;
        n_upper     = r_upper;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        o_cmd_pop   = 1'b0;
        unique case (r_state)
            itaf_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_sign    = i_cmd.sign_char;
                    n_upper   = i_cmd.upper_case;
                    n_prec    = i_cmd.precision;
                    n_bin     = i_cmd.value;
                    n_step    = '0;
                    n_idx     = IDX_W'(MAX_DIGITS - 1);
                    // hex digits are the nibbles themselves
                    n_digits  = i_cmd.hex_base ? BCD_W'(i_cmd.value) : '0;
                end
            end
            itaf_pkg::ST_CONV: begin
                n_digits = {w_adj[BCD_W-2:0], r_bin[VAL_W-1]};
                n_bin    = {r_bin[VAL_W-2:0], 1'b0};
                n_step   = r_step + STEP_W'(1);
            end
            itaf_pkg::ST_SCAN: begin
                if (w_found) begin
                    n_pad = w_scan_pad;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            itaf_pkg::ST_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_sign;
                    n_out_last  = 1'b0;
                end
            end
            itaf_pkg::ST_PAD: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itaf_pkg::CH_ZERO;
                    n_out_last  = 1'b0;
                    n_pad       = r_pad - PREC_W'(1);
                end
            end
            itaf_pkg::ST_DIGIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(w_nib, r_upper);
                    n_out_last  = (r_idx == '0);
                    if (r_idx != '0) begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itaf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_digits   <= n_digits;
        r_step     <= n_step;
        r_idx      <= n_idx;
        r_pad      <= n_pad;
        r_prec     <= n_prec;
        r_sign     <= n_sign;
        r_upper    <= n_upper;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

// File: rtl/core/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter.
// Usage:
//   Slave stream: one word per number. tdata holds value [63:0],
//   upper_case [64], precision [70:65], space_sign [71], plus_sign [72],
//   zeros above. tuser holds hex_base [0], negative [1], sign_enable [2].
//   Master stream: one ASCII character per word in tdata [7:0], most
//   significant first; tlast marks the final character of a number.
// Sequence:
//   A hex number passes setup and the leading digit scan; a decimal
//   number also passes the shift-and-adjust steps of the BCD converter
//   before the scan. Characters then leave at one per cycle while the
//   receiver holds tready high, sign, padding zeros and digits, up to
//   max(MAX_DIGITS, MAX_PRECISION)+1 of them. The back part takes one
//   number at a time; the BCD converter and the single character output
//   register set how fast numbers pass through it.
//   A two-entry command queue lets the slave side accept up to two more
//   numbers while the back part is still converting or emitting.
// Reset (synchronous, active low) empties the queue, returns the back
//   part to idle and drops the master tvalid. When the receiver holds
//   tready low the current character is held, the back part waits before
//   its next character, and the slave side stalls once the queue is full.
module integer_to_ascii_formatter_unit #(
    parameter int MAX_PRECISION = 32,
    parameter int MAX_DIGITS    = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // value[63:0], upper_case[64], precision[70:65], space_sign[71], plus_sign[72]
    input  logic [itaf_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // hex_base[0], negative[1], sign_enable[2]
    input  logic [itaf_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_char[7:0]
    output logic [itaf_pkg::CHAR_W-1:0]     o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    itaf_pkg::t_cmd w_push_data;
    itaf_pkg::t_cmd w_pop_data;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;

    // front: handshake and classification
    itaf_front #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_queue_full    (w_full),
        .o_push          (w_push),
        .o_push_data     (w_push_data)
    );

    // decoupling queue
    itaf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    // back: convert, scan, emit
    itaf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (!w_empty),
        .i_cmd           (w_pop_data),
        .o_cmd_pop       (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// File: rtl/core/itaf_checker.sv
// Port-level checker for the formatter, bound to the top level.
`include "assert_macros.svh"

module itaf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_s_axis_tready,
    input  logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [itaf_pkg::CHAR_W-1:0] o_m_axis_tdata,
    input  logic                        o_m_axis_tlast
);

    logic w_is_digit;
    logic w_is_hex;
    logic w_is_sign;

    assign w_is_digit = (o_m_axis_tdata >= itaf_pkg::CH_ZERO) &&
                        (o_m_axis_tdata <= itaf_pkg::CH_NINE);
    assign w_is_hex   = ((o_m_axis_tdata >= itaf_pkg::CH_LOWER_A) &&
                         (o_m_axis_tdata <= itaf_pkg::CH_LOWER_F)) ||
                        ((o_m_axis_tdata >= itaf_pkg::CH_UPPER_A) &&
                         (o_m_axis_tdata <= itaf_pkg::CH_UPPER_F));
    assign w_is_sign  = (o_m_axis_tdata == itaf_pkg::CH_MINUS) ||
                        (o_m_axis_tdata == itaf_pkg::CH_SPACE) ||
                        (o_m_axis_tdata == itaf_pkg::CH_PLUS);

    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output word changed")
    `ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")
    `ASSERT_ALWAYS(a_reset_ready, i_clk, !i_rst_n |=> o_s_axis_tready, "input not ready after reset")
    `ASSERT_SYNC(a_char_set, i_clk, i_rst_n, o_m_axis_tvalid |-> w_is_digit || w_is_hex || w_is_sign, "character outside the allowed set")
    `ASSERT_SYNC(a_last_digit, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast |-> w_is_digit || w_is_hex, "final character is not a digit")

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (.*);
